FILE: rtl/core/gbn_pkg.sv
package gbn_pkg;

   // Field widths fixed by the register map and the packet format
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 20;
   localparam int LAST_SEQ_W  = 20;
   localparam int WIN_W       = 11;
   localparam int TIMER_W     = 16;
   localparam int RX_TYPE_W   = 2;

   // Register defaults
   localparam int LAST_SEQ_RESET = 19999;
   localparam int WIN_RESET      = 4;
   localparam int TIMEOUT_RESET  = 600;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_SEQ = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT  = 2'd2;

   // Received packet types
   localparam logic [RX_TYPE_W-1:0] RX_SYN_ACK = 2'd0;
   localparam logic [RX_TYPE_W-1:0] RX_ACK_FIN = 2'd1;

   typedef enum logic [2:0] {
      TX_NONE = 3'd0,
      TX_SYN  = 3'd1,
      TX_DATA = 3'd2,
      TX_ACK  = 3'd3,
      TX_FIN  = 3'd4
   } tx_kind_type;

   typedef enum logic [4:0] {
      PH_HANDSHAKE   = 5'b00001,
      PH_WAIT_SYNACK = 5'b00010,
      PH_DATA        = 5'b00100,
      PH_WAIT_FINACK = 5'b01000,
      PH_CLOSED      = 5'b10000
   } phase_type;

endpackage

FILE: rtl/core/go_back_n_sender.sv
// Each item's results are written into the result queue when the item is accepted.
// Throughput: one item per cycle while req_tready is high; an item that sends DATA and FIN
//   gives two result beats on the output port. A four-entry result queue
//   decouples the sides; req_tready drops only when fewer than two entries are free.
// Reset (synchronous, active high): handshake phase, counters and timer cleared,
//   registers back to defaults, result queue emptied.
module go_back_n_sender
   import gbn_pkg::*;
#(
   parameter int SEQ_WIDTH = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [CSR_INDEX_W-1:0]                csr_index,
   input  logic [CSR_DATA_W-1:0]                 csr_wdata,
   // input items
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SEQ_WIDTH+7)/8)*8-1:0]        req_tdata,  // rx_sequence
   input  logic [RX_TYPE_W:0]                    req_tuser,  // command, rx_type
   // results
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((SEQ_WIDTH+8)/8)*8-1:0]        rsp_tdata,  // tx_sequence, closed
   output logic [2:0]                            rsp_tuser,  // tx_kind
   output logic                                  rsp_tlast
);

   localparam int NS_W     = SEQ_WIDTH + 1;
   localparam int LAST_W   = (SEQ_WIDTH < LAST_SEQ_W) ? SEQ_WIDTH : LAST_SEQ_W;
   localparam int SUM_W    = ((NS_W > WIN_W) ? NS_W : WIN_W) + 1;
   localparam int Q_DEPTH  = 4;
   localparam int Q_PTR_W  = $clog2(Q_DEPTH);
   localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      tx_kind_type          kind;
      logic [SEQ_WIDTH-1:0] seq;
      logic                 closed;
      logic                 last;
   } result_type;

   // configuration registers
   logic [LAST_W-1:0]  last_seq_ff;
   logic [WIN_W-1:0]   window_ff;
   logic [TIMER_W-1:0] timeout_ff;

   // protocol state
   phase_type          phase_ff, phase_in;
   logic [NS_W-1:0]    next_send_ff, next_send_in;
   logic [NS_W-1:0]    acked_ff, acked_in;
   logic [TIMER_W-1:0] ticks_ff, ticks_in, ticks_inc;

   // result queue
   result_type         queue_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;

   // per-item decode
   logic                 got;
   logic [RX_TYPE_W-1:0] rx_type;
   logic [SEQ_WIDTH-1:0] rx_seq;
   logic [NS_W-1:0]      rx_seq_ext;
   logic [NS_W-1:0]      last_ext;
   logic                 timeout;
   logic                 send_ok;
   logic                 req_accept;
   logic                 rsp_accept;
   tx_kind_type          kind0, kind1;
   logic [NS_W-1:0]      seq0, seq1;
   logic                 two_res;
   result_type           res0, res1;

   assign got        = req_tuser[0];
   assign rx_type    = req_tuser[RX_TYPE_W:1];
   assign rx_seq     = req_tdata[SEQ_WIDTH-1:0];
   assign rx_seq_ext = NS_W'(rx_seq);
   assign last_ext   = NS_W'(last_seq_ff);

   assign csr_ready  = 1'b1;
   assign req_tready = (count_ff <= Q_CNT_W'(Q_DEPTH - 2));
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_accept = rsp_tvalid && rsp_tready;

   assign ticks_inc = (ticks_ff != {TIMER_W{1'b1}}) ? ticks_ff + 1'b1 : ticks_ff;
   assign timeout   = !got && (ticks_inc >= timeout_ff);
   assign send_ok   = (SUM_W'(next_send_ff) < SUM_W'(acked_ff) + SUM_W'(window_ff))
                      && (next_send_ff <= last_ext);

   always_comb begin
      phase_in     = phase_ff;
      next_send_in = next_send_ff;
      acked_in     = acked_ff;
      ticks_in     = ticks_inc;
      kind0        = TX_NONE;
      seq0         = '0;
      kind1        = TX_NONE;
      seq1         = '0;
      two_res      = 1'b0;
      case (phase_ff)
         PH_HANDSHAKE: begin
            kind0    = TX_SYN;
            phase_in = PH_WAIT_SYNACK;
         end
         PH_WAIT_SYNACK: begin
            if (got) begin
               if (rx_type == RX_SYN_ACK && rx_seq == '0) begin
                  ticks_in = '0;
                  kind0    = TX_ACK;
                  phase_in = PH_DATA;
               end
            end else if (timeout) begin
               ticks_in = '0;
               phase_in = PH_HANDSHAKE;
            end
         end
         PH_DATA: begin
            if (send_ok) begin
               kind0        = TX_DATA;
               seq0         = next_send_ff;
               next_send_in = next_send_ff + 1'b1;
            end
            if (got) begin
               if (acked_ff <= rx_seq_ext) begin
                  acked_in = rx_seq_ext + 1'b1;
                  ticks_in = '0;
               end
            end else if (timeout) begin
               ticks_in     = '0;
               next_send_in = acked_ff;
            end
            if (acked_in > last_ext) begin
               phase_in = PH_WAIT_FINACK;
               // FIN rides second when a DATA beat went out first
               if (send_ok) begin
                  two_res = 1'b1;
                  kind1   = TX_FIN;
                  seq1    = acked_in;
               end else begin
                  kind0 = TX_FIN;
                  seq0  = acked_in;
               end
            end
         end
         PH_WAIT_FINACK: begin
            if (got) begin
               if (rx_type == RX_ACK_FIN && rx_seq_ext == last_ext + 1'b1) begin
                  phase_in = PH_CLOSED;
               end
            end else if (timeout) begin
               ticks_in = '0;
               kind0    = TX_FIN;
               seq0     = acked_ff;
            end
         end
         default: begin
            phase_in = PH_CLOSED;
         end
      endcase
   end

   always_comb begin
      res0.kind   = kind0;
      res0.seq    = seq0[SEQ_WIDTH-1:0];
      res0.closed = (phase_in == PH_CLOSED);
      res0.last   = !two_res;
      res1.kind   = kind1;
      res1.seq    = seq1[SEQ_WIDTH-1:0];
      res1.closed = (phase_in == PH_CLOSED);
      res1.last   = 1'b1;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_accept) begin
         wr_ptr_in = wr_ptr_ff + (two_res ? Q_PTR_W'(2) : Q_PTR_W'(1));
         count_in  = count_in + (two_res ? Q_CNT_W'(2) : Q_CNT_W'(1));
      end
      if (rsp_accept) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
         count_in  = count_in - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff  <= LAST_W'(LAST_SEQ_RESET);
         window_ff    <= WIN_W'(WIN_RESET);
         timeout_ff   <= TIMER_W'(TIMEOUT_RESET);
         phase_ff     <= PH_HANDSHAKE;
         next_send_ff <= '0;
         acked_ff     <= '0;
         ticks_ff     <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LAST_SEQ: last_seq_ff <= csr_wdata[LAST_W-1:0];
               CSR_WINDOW:   window_ff   <= csr_wdata[WIN_W-1:0];
               CSR_TIMEOUT:  timeout_ff  <= csr_wdata[TIMER_W-1:0];
               default: ;
            endcase
         end
         if (req_accept) begin
            phase_ff     <= phase_in;
            next_send_ff <= next_send_in;
            acked_ff     <= acked_in;
            ticks_ff     <= ticks_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         queue_ff[wr_ptr_ff] <= res0;
         if (two_res) begin
            queue_ff[wr_ptr_ff + 1'b1] <= res1;
         end
      end
   end

   always_comb begin
      rsp_tdata            = '0;
      rsp_tdata[SEQ_WIDTH-1:0] = queue_ff[rd_ptr_ff].seq;
      rsp_tdata[SEQ_WIDTH] = queue_ff[rd_ptr_ff].closed;
      rsp_tuser            = queue_ff[rd_ptr_ff].kind;
      rsp_tlast            = queue_ff[rd_ptr_ff].last;
   end

   // queue occupancy never passes its depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(Q_DEPTH))
      else $error("result queue overflow");

   // only the data phase can produce a DATA+FIN pair
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && two_res) |-> (phase_ff == PH_DATA && kind0 == TX_DATA))
      else $error("two results outside data phase");

   // a two-result item without a pop grows the queue by two
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && two_res && !rsp_accept) |=> count_ff == $past(count_ff) + 2'd2)
      else $error("second result lost");

   // once closed, the link stays closed
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CLOSED) |=> (phase_ff == PH_CLOSED))
      else $error("left closed phase");

endmodule

FILE: tb/go_back_n_sender_test.sv
module go_back_n_sender_test;
   timeunit 1ns;
   timeprecision 1ps;
   import gbn_pkg::*;

   localparam int SEQ_W       = 20;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MAX_REPORTS = 10;

   // rx_type codes that the package leaves unnamed
   localparam logic [RX_TYPE_W-1:0] RX_PLAIN_ACK = 2'd2;
   localparam logic [RX_TYPE_W-1:0] RX_UNUSED    = 2'd3;

   typedef struct packed {
      tx_kind_type      kind;
      logic [SEQ_W-1:0] seq;
      logic             closed;
      logic             last;
   } tx_beat_type;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [23:0]            req_tdata  = '0;  // rx_sequence
   logic [RX_TYPE_W:0]     req_tuser  = '0;  // command, rx_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [23:0]            rsp_tdata;        // tx_sequence, closed
   logic [2:0]             rsp_tuser;        // tx_kind
   logic                   rsp_tlast;

   // link state as the sender should see it
   logic [SEQ_W-1:0]   cfg_last_seq = SEQ_W'(LAST_SEQ_RESET);
   logic [WIN_W-1:0]   cfg_window   = WIN_W'(WIN_RESET);
   logic [TIMER_W-1:0] cfg_timeout  = TIMER_W'(TIMEOUT_RESET);
   phase_type          link_phase   = PH_HANDSHAKE;
   logic [SEQ_W:0]     send_seq     = '0;
   logic [SEQ_W:0]     acked        = '0;
   logic [TIMER_W-1:0] idle_ticks   = '0;

   tx_beat_type expected_tx[$];
   int          mismatches  = 0;
   int          cycle_count = 0;
   bit          steady      = 1'b0;

   go_back_n_sender DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= 13);
   end

   function automatic tx_beat_type tx_beat(input tx_kind_type kind,
                                           input logic [SEQ_W-1:0] seq);
      tx_beat_type b;
      b.kind   = kind;
      b.seq    = seq;
      b.closed = 1'b0;
      b.last   = 1'b0;
      return b;
   endfunction

   // Advance the link by one loop pass and queue the beats it sends.
   task automatic predict_item(input logic got, input logic [RX_TYPE_W-1:0] rtype,
                               input logic [SEQ_W-1:0] rseq);
      tx_beat_type sent[$];
      tx_beat_type b;
      bit          timed_out;
      if (idle_ticks != '1)
         idle_ticks++;
      timed_out = !got && idle_ticks >= cfg_timeout;
      case (link_phase)
         PH_HANDSHAKE: begin
            sent.push_back(tx_beat(TX_SYN, '0));
            link_phase = PH_WAIT_SYNACK;
         end
         PH_WAIT_SYNACK: begin
            if (got) begin
               if (rtype == RX_SYN_ACK && rseq == '0) begin
                  idle_ticks = '0;
                  sent.push_back(tx_beat(TX_ACK, '0));
                  link_phase = PH_DATA;
               end
            end else if (timed_out) begin
               idle_ticks = '0;
               link_phase = PH_HANDSHAKE;
            end
         end
         PH_DATA: begin
            if (int'(send_seq) < int'(acked) + int'(cfg_window) &&
                send_seq <= {1'b0, cfg_last_seq}) begin
               sent.push_back(tx_beat(TX_DATA, send_seq[SEQ_W-1:0]));
               send_seq++;
            end
            // cumulative ack, type not looked at
            if (got) begin
               if (acked <= {1'b0, rseq}) begin
                  acked      = {1'b0, rseq} + 1'b1;
                  idle_ticks = '0;
               end
            end else if (timed_out) begin
               idle_ticks = '0;
               send_seq   = acked;
            end
            if (acked > {1'b0, cfg_last_seq}) begin
               link_phase = PH_WAIT_FINACK;
               sent.push_back(tx_beat(TX_FIN, acked[SEQ_W-1:0]));
            end
         end
         PH_WAIT_FINACK: begin
            if (got) begin
               if (rtype == RX_ACK_FIN && {1'b0, rseq} == {1'b0, cfg_last_seq} + 21'd1)
                  link_phase = PH_CLOSED;
            end else if (timed_out) begin
               idle_ticks = '0;
               sent.push_back(tx_beat(TX_FIN, acked[SEQ_W-1:0]));
            end
         end
         default: link_phase = PH_CLOSED;
      endcase
      if (sent.size() == 0)
         sent.push_back(tx_beat(TX_NONE, '0));
      foreach (sent[i]) begin
         b        = sent[i];
         b.closed = (link_phase == PH_CLOSED);
         b.last   = (i == sent.size() - 1);
         expected_tx.push_back(b);
      end
   endtask

   task automatic send_item(input logic got, input logic [RX_TYPE_W-1:0] rtype,
                            input logic [SEQ_W-1:0] rseq);
      int gap;
      gap = (!steady && $urandom_range(99) < 13) ? $urandom_range(2, 1) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, rseq};
      req_tuser  <= {rtype, got};
      do @(posedge clock); while (!req_tready);
      predict_item(got, rtype, rseq);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_tx.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (index)
         CSR_LAST_SEQ: cfg_last_seq = value[SEQ_W-1:0];
         CSR_WINDOW:   cfg_window   = value[WIN_W-1:0];
         CSR_TIMEOUT:  cfg_timeout  = value[TIMER_W-1:0];
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      tx_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tx.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected beat: kind %0d seq %0d closed %0b last %0b",
                        rsp_tuser, rsp_tdata[SEQ_W-1:0], rsp_tdata[SEQ_W], rsp_tlast);
         end else begin
            want = expected_tx.pop_front();
            if (rsp_tuser != want.kind || rsp_tdata[SEQ_W-1:0] != want.seq ||
                rsp_tdata[SEQ_W] != want.closed || rsp_tlast != want.last) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("mismatch: want %0d %0d %0b %0b, got %0d %0d %0b %0b",
                           want.kind, want.seq, want.closed, want.last, rsp_tuser,
                           rsp_tdata[SEQ_W-1:0], rsp_tdata[SEQ_W], rsp_tlast);
            end
         end
      end
   end

   task automatic test_handshake();
      // packet during the handshake is ignored, SYN goes out anyway
      send_item(1'b1, RX_SYN_ACK, '0);
      send_item(1'b1, RX_SYN_ACK, 20'hFFFFF);
      send_item(1'b1, RX_ACK_FIN, '0);
      send_item(1'b1, RX_UNUSED, '0);
      send_item(1'b0, RX_PLAIN_ACK, 20'h5A5A5);
      write_register(CSR_TIMEOUT, 20'd2);
      send_item(1'b0, RX_SYN_ACK, '0);
      send_item(1'b0, RX_SYN_ACK, '0);
      // zero timeout: the first tick while waiting gives up
      write_register(CSR_TIMEOUT, 20'd0);
      send_item(1'b0, RX_SYN_ACK, '0);
      send_item(1'b0, RX_SYN_ACK, '0);
      write_register(CSR_TIMEOUT, 20'd40);
      write_register(CSR_LAST_SEQ, 20'd1048574);
      send_item(1'b1, RX_SYN_ACK, '0);
   endtask

   task automatic test_window_and_rewind();
      // closed window: nothing sent, an ack still moves the base
      write_register(CSR_WINDOW, 20'd0);
      send_item(1'b0, RX_PLAIN_ACK, '0);
      send_item(1'b1, RX_PLAIN_ACK, '0);
      write_register(CSR_WINDOW, 20'd1);
      send_item(1'b0, RX_PLAIN_ACK, '0);
      send_item(1'b0, RX_PLAIN_ACK, '0);
      send_item(1'b0, RX_PLAIN_ACK, '0);
      send_item(1'b1, RX_SYN_ACK, 20'd1);
      write_register(CSR_WINDOW, 20'd1024);
      write_register(CSR_TIMEOUT, 20'd1);
      send_item(1'b0, RX_PLAIN_ACK, '0);
      send_item(1'b0, RX_PLAIN_ACK, '0);
      send_item(1'b1, RX_ACK_FIN, 20'd2);
   endtask

   task automatic test_random_traffic();
      int wins[6] = '{4, 1, 1024, 7, 0, 0};
      int tos[6]  = '{600, 1, 50, 12, 0, 0};
      int pick;
      int lo;
      int hi;
      logic [RX_TYPE_W-1:0] rtype;
      for (int p = 0; p < 6; p++) begin
         write_register(CSR_WINDOW,
                        CSR_DATA_W'(p < 4 ? wins[p] : $urandom_range(1024, 1)));
         write_register(CSR_TIMEOUT,
                        CSR_DATA_W'(p < 4 ? tos[p] : $urandom_range(300, 1)));
         steady = (p == 2);
         repeat (280) begin
            pick  = $urandom_range(99);
            rtype = RX_TYPE_W'($urandom_range(3));
            lo    = int'(acked);
            hi    = (int'(send_seq) > lo) ? int'(send_seq) - 1 : lo;
            if (pick < 45)
               send_item(1'b0, rtype, SEQ_W'($urandom));
            else if (pick < 80)
               send_item(1'b1, rtype, SEQ_W'($urandom_range(hi, lo)));
            else if (pick < 90)
               send_item(1'b1, rtype, SEQ_W'(lo == 0 ? 0 : $urandom_range(lo - 1, 0)));
            else
               send_item(1'b1, rtype, SEQ_W'(lo + $urandom_range(20, 0)));
         end
      end
      steady = 1'b0;
   endtask

   task automatic test_fin_entry();
      // all-ones final sequence: ack of it wraps the FIN number, ACK_FIN can never match
      write_register(CSR_LAST_SEQ, 20'hFFFFF);
      write_register(CSR_WINDOW, 20'd16);
      write_register(CSR_TIMEOUT, 20'd3);
      send_item(1'b1, RX_PLAIN_ACK, 20'hFFFFF);
      send_item(1'b1, RX_ACK_FIN, '0);
      send_item(1'b1, RX_ACK_FIN, 20'hFFFFF);
      repeat (4) send_item(1'b0, RX_SYN_ACK, '0);
   endtask

   task automatic test_long_timeout();
      // top timeout: packets never time out and a lone tick stays short of it
      write_register(CSR_TIMEOUT, 20'hFFFF);
      repeat (20) send_item(1'b1, RX_TYPE_W'($urandom_range(3)), SEQ_W'($urandom));
      send_item(1'b0, RX_PLAIN_ACK, '0);
   endtask

   task automatic test_close();
      write_register(CSR_LAST_SEQ, 20'd0);
      send_item(1'b1, RX_PLAIN_ACK, 20'd1);
      send_item(1'b1, RX_ACK_FIN, 20'd2);
      send_item(1'b1, RX_ACK_FIN, 20'd1);
      send_item(1'b0, RX_PLAIN_ACK, '0);
      send_item(1'b1, RX_SYN_ACK, '0);
      send_item(1'b1, RX_ACK_FIN, 20'd1);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_handshake();
      test_window_and_rewind();
      test_random_traffic();
      test_fin_entry();
      test_long_timeout();
      test_close();
      wait_drained();
      if (mismatches == 0 && expected_tx.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
